### hdl/rc4kx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 keystream XOR unit package
// Shared types and function codes for the keystream unit and its parts.
// ----------------------------------------------------------------------------
package rc4kx_pkg;

   localparam int BYTE_W = 8;

   typedef logic [BYTE_W-1:0] octet_type;

   // function codes of a request
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_GEN  = 1'b1;

   typedef struct packed {
      logic      func;
      octet_type entry_index;
      octet_type data_byte;
   } req_type;

   typedef struct packed {
      octet_type out_byte;
      octet_type key_byte;
      logic      valid_res;
   } rsp_type;

   // one write and one read of the permutation memory per cycle
   typedef struct packed {
      logic      wr_en;
      octet_type wr_addr;
      octet_type wr_data;
      logic      rd_en;
      octet_type rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } rsp_push_type;

endpackage

### hdl/rc4kx_sbox_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 permutation memory
// 256 x 8 memory, one write and one registered read per cycle. A read that
// meets a write to the same entry returns the written byte.
// ----------------------------------------------------------------------------
module rc4kx_sbox_mem (
   input  logic                    clock,
   input  logic                    reset,
   input  rc4kx_pkg::mem_req_type  mem_req,
   output rc4kx_pkg::octet_type    rd_data
);
   import rc4kx_pkg::*;

   octet_type sbox_mem [256];
   octet_type rd_raw_ff;
   octet_type fwd_data_ff;
   logic      fwd_hit_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         sbox_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_raw_ff   <= sbox_mem[mem_req.rd_addr];
         fwd_data_ff <= mem_req.wr_data;
      end
   end

   // hold the bypass flag with the read data it belongs to
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (mem_req.rd_en) begin
         fwd_hit_ff <= mem_req.wr_en && (mem_req.wr_addr == mem_req.rd_addr);
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_raw_ff;

endmodule

### hdl/rc4kx_rsp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 response queue
// Two-entry result queue with two push ports; the older result enters first.
// ----------------------------------------------------------------------------
module rc4kx_rsp_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  rc4kx_pkg::rsp_push_type push_old,
   input  rc4kx_pkg::rsp_push_type push_new,
   input  logic                    pop,
   output rc4kx_pkg::rsp_type      head,
   output logic [1:0]              count
);
   import rc4kx_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       new_slot;

   assign new_slot  = push_old.valid ? ~wr_ptr_ff : wr_ptr_ff;
   assign wr_ptr_in = wr_ptr_ff ^ (push_old.valid ^ push_new.valid);
   assign rd_ptr_in = rd_ptr_ff ^ pop;
   assign count_in  = count_ff + 2'(push_old.valid) + 2'(push_new.valid) - 2'(pop);

   always_ff @(posedge clock) begin
      if (push_old.valid) begin
         entry_ff[wr_ptr_ff] <= push_old.data;
      end
      if (push_new.valid) begin
         entry_ff[new_slot] <= push_new.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign count = count_ff;

   // never push past the two entries
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !pop) |-> (!push_old.valid && !push_new.valid))
      else $error("response queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1 && !pop) |-> !(push_old.valid && push_new.valid))
      else $error("double push into a half-full response queue");

endmodule

### hdl/rc4_keystream_xor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 keystream XOR unit
// RC4 output stage: holds the permutation in a memory, steps the two
// pointers, swaps entries and XORs each data byte with the keystream byte.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------
//   req     | in        | req_valid/req_ready  | req_data (func, index, byte)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_data (out, key, valid)
//
// A generate transfer issues the S[i] read on acceptance, then passes
// through ST_RD_J, ST_SWAP and ST_KEY, where its result enters the response
// queue; the next generate can be accepted in ST_KEY when the queue is empty.
// The single read port paces it: S[i], then S[j], then S[S[i]+S[j]].
// Load transfers, and generates before any load, answer zero on acceptance.
// Reset clears pointers, the loaded flag and the queue; the memory keeps
// its contents and is undefined until loaded.
// A full response queue stalls the unit in its last step; requests wait.
//
module rc4_keystream_xor_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rc4kx_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rc4kx_pkg::rsp_type rsp_data
);
   import rc4kx_pkg::*;

   // engine steps
   localparam logic [1:0] ST_IDLE = 2'd0;  // wait; S[i] read issued on start
   localparam logic [1:0] ST_RD_J = 2'd1;  // take S[i], form j, read S[j]
   localparam logic [1:0] ST_SWAP = 2'd2;  // write S[i], read S[t]
   localparam logic [1:0] ST_KEY  = 2'd3;  // write S[j], emit key byte

   logic [1:0]   state_ff, state_in;
   octet_type    ptr_i_ff, ptr_i_in;
   octet_type    ptr_j_ff, ptr_j_in;
   logic         loaded_ff, loaded_in;
   octet_type    i_ff, i_in;
   octet_type    j_ff, j_in;
   octet_type    a_ff, a_in;
   octet_type    t_ff, t_in;
   octet_type    data_ff, data_in;
   logic         ldw_ff, ldw_in;
   octet_type    ldw_idx_ff, ldw_idx_in;
   octet_type    ldw_data_ff, ldw_data_in;

   mem_req_type  mem_req;
   octet_type    rd_data;
   rsp_push_type push_old;
   rsp_push_type push_new;
   rsp_type      head;
   logic [1:0]   fifo_count;

   logic         accept;
   logic         gen_start;
   logic         key_push;
   logic         rsp_pop;
   octet_type    i_next;
   octet_type    j_calc;
   octet_type    key_byte;

   assign accept    = req_valid && req_ready;
   assign gen_start = accept && (req_data.func == FUNC_GEN) && loaded_ff;
   assign i_next    = ptr_i_ff + 8'd1;
   assign j_calc    = ptr_j_ff + rd_data;
   assign rsp_pop   = rsp_valid && rsp_ready;

   // last step may finish when the queue has room, counting this pop
   assign key_push  = (state_ff == ST_KEY) && ((fifo_count != 2'd2) || rsp_ready);

   // take a request when idle with room for an immediate answer, or overlap
   // the last step when the queue is empty (room for both results)
   assign req_ready = ((state_ff == ST_IDLE) && (fifo_count != 2'd2)) ||
                      ((state_ff == ST_KEY)  && (fifo_count == 2'd0));

   // S[t] is read in ST_SWAP, before S[j] is written in ST_KEY: bypass a from the swap
   assign key_byte  = (t_ff == j_ff) ? a_ff : rd_data;

   // memory port steering
   always_comb begin
      mem_req.wr_en   = ldw_ff;
      mem_req.wr_addr = ldw_idx_ff;
      mem_req.wr_data = ldw_data_ff;
      mem_req.rd_en   = gen_start;
      mem_req.rd_addr = i_next;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_RD_J: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = j_calc;
         end
         ST_SWAP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = i_ff;
            mem_req.wr_data = rd_data;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = a_ff + rd_data;
         end
         ST_KEY: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = j_ff;
            mem_req.wr_data = a_ff;
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in    = state_ff;
      ptr_i_in    = ptr_i_ff;
      ptr_j_in    = ptr_j_ff;
      loaded_in   = loaded_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      a_in        = a_ff;
      t_in        = t_ff;
      data_in     = data_ff;
      ldw_in      = 1'b0;
      ldw_idx_in  = req_data.entry_index;
      ldw_data_in = req_data.data_byte;

      unique case (state_ff)
         ST_IDLE: begin
            if (gen_start) begin
               state_in = ST_RD_J;
            end
         end
         ST_RD_J: begin
            a_in     = rd_data;
            j_in     = j_calc;
            ptr_j_in = j_calc;
            state_in = ST_SWAP;
         end
         ST_SWAP: begin
            t_in     = a_ff + rd_data;
            state_in = ST_KEY;
         end
         ST_KEY: begin
            if (key_push) begin
               state_in = gen_start ? ST_RD_J : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // advance i and latch the data byte on a new generate
      if (gen_start) begin
         ptr_i_in = i_next;
         i_in     = i_next;
         data_in  = req_data.data_byte;
      end

      // load: post the entry write, drop both pointers, mark loaded
      if (accept && (req_data.func == FUNC_LOAD)) begin
         ldw_in    = 1'b1;
         ptr_i_in  = '0;
         ptr_j_in  = '0;
         loaded_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ptr_i_ff  <= '0;
         ptr_j_ff  <= '0;
         loaded_ff <= 1'b0;
         ldw_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ptr_i_ff  <= ptr_i_in;
         ptr_j_ff  <= ptr_j_in;
         loaded_ff <= loaded_in;
         ldw_ff    <= ldw_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      a_ff        <= a_in;
      t_ff        <= t_in;
      data_ff     <= data_in;
      ldw_idx_ff  <= ldw_idx_in;
      ldw_data_ff <= ldw_data_in;
   end

   // results: keystream from the engine, zero answers straight from the request
   always_comb begin
      push_old.valid          = key_push;
      push_old.data.out_byte  = data_ff ^ key_byte;
      push_old.data.key_byte  = key_byte;
      push_old.data.valid_res = 1'b1;
      push_new.valid          = accept && !gen_start;
      push_new.data           = '0;
   end

   rc4kx_sbox_mem u_sbox_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   rc4kx_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push_old (push_old),
      .push_new (push_new),
      .pop      (rsp_pop),
      .head     (head),
      .count    (fifo_count)
   );

   assign rsp_valid = (fifo_count != 2'd0);
   assign rsp_data  = head;

   // the engine only starts on an accepted generate after a load
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_J) |->
         $past(req_valid && req_ready && (req_data.func == FUNC_GEN) && loaded_ff))
      else $error("engine started without a generate transfer");

   // a posted load write never competes with the swap writes
   assert property (@(posedge clock) disable iff (reset)
      ldw_ff |-> ((state_ff == ST_IDLE) || (state_ff == ST_RD_J)))
      else $error("load write collides with swap write");

   // i steps by one for each generate
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_J) |-> (ptr_i_ff == 8'($past(ptr_i_ff) + 8'd1)))
      else $error("pointer i did not advance by one");

endmodule

### dv/tb_rc4_keystream_xor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 keystream XOR unit testbench
// Drives load and generate transfers with random gaps, mirrors the RC4
// output stage in a local permutation model and checks every response
// transfer, field by field, against the predicted keystream and XOR result.
// ----------------------------------------------------------------------------
module tb_rc4_keystream_xor_unit;
   import rc4kx_pkg::*;

   localparam int RANDOM_ITEMS = 520;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 16;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rc4_keystream_xor_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 4 ns period: high half, then low half
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Local copy of the RC4 output stage: permutation, pointers, loaded flag
   // ------------------------------------------------------------------------
   octet_type sbox [256];
   octet_type sbox_i  = '0;
   octet_type sbox_j  = '0;
   logic      sbox_loaded = 1'b0;

   req_type   pending_req_q [$];   // items waiting for the driver
   rsp_type   keystream_out_q [$]; // predicted responses, oldest first

   int        accepted_count = 0;
   int        mismatch_count = 0;
   int        cycle_count    = 0;
   rsp_type   want_rsp;

   // Advance the local RC4 state by one accepted transfer and queue the
   // response it must produce.
   task automatic rc4_advance(input req_type r);
      rsp_type   res;
      octet_type ni;
      octet_type nj;
      octet_type held;
      octet_type t;
      res = '0;
      if (r.func == FUNC_LOAD) begin
         // a load writes one entry and restarts the stream from the top
         sbox[r.entry_index] = r.data_byte;
         sbox_i      = '0;
         sbox_j      = '0;
         sbox_loaded = 1'b1;
      end else if (sbox_loaded) begin
         ni       = sbox_i + 8'd1;
         nj       = sbox_j + sbox[ni];
         held     = sbox[ni];
         sbox[ni] = sbox[nj];
         sbox[nj] = held;
         t        = sbox[ni] + sbox[nj];
         res.key_byte  = sbox[t];
         res.out_byte  = r.data_byte ^ sbox[t];
         res.valid_res = 1'b1;
         sbox_i   = ni;
         sbox_j   = nj;
      end
      // a generate before any load leaves the state alone and answers zero
      keystream_out_q.push_back(res);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------------
   task automatic queue_item(input logic f, input octet_type idx, input octet_type d);
      pending_req_q.push_back(req_type'{func: f, entry_index: idx, data_byte: d});
   endtask

   // Load a fresh random permutation, entry order shuffled as well.
   task automatic queue_full_load();
      octet_type vals [256];
      octet_type order [256];
      octet_type t;
      int        m;
      for (int k = 0; k < 256; k++) begin
         vals[k]  = octet_type'(k);
         order[k] = octet_type'(k);
      end
      for (int k = 255; k > 0; k--) begin
         m        = $urandom_range(0, k);
         t        = vals[k];
         vals[k]  = vals[m];
         vals[m]  = t;
         m        = $urandom_range(0, k);
         t        = order[k];
         order[k] = order[m];
         order[m] = t;
      end
      for (int k = 0; k < 256; k++) begin
         queue_item(FUNC_LOAD, order[k], vals[k]);
      end
   endtask

   // Gap length: mostly none or short, now and then long; a calm stretch
   // forces a run of zero gaps.
   function automatic int next_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(16, 48);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: change inputs on the falling edge only
   // ------------------------------------------------------------------------
   logic req_fire  = 1'b0;
   logic rsp_fire  = 1'b0;
   int   req_gap   = 0;
   int   req_calm  = 0;
   int   rsp_stall = 0;
   int   rsp_calm  = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         // channel free: idle out the gap, then present the next item
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (pending_req_q.size() > 0) begin
            req_data  <= pending_req_q.pop_front();
            req_valid <= 1'b1;
            req_gap = next_gap(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
      // otherwise hold valid and payload until the transfer happens
   end

   // Response ready: stall after some transfers and now and then at random,
   // so that back-pressure lands on the unit's last step and on its request channel
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_stall == 0 && (rsp_fire || $urandom_range(0, 7) == 0)) begin
            rsp_stall = next_gap(rsp_calm);
         end
         if (rsp_stall > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: sample both channels on the rising edge; predict first, then
   // check, so a same-edge push always precedes the pop
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         rsp_fire <= rsp_valid && rsp_ready;
         if (req_valid && req_ready) begin
            rc4_advance(req_data);
            accepted_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (keystream_out_q.size() == 0) begin
               $error("response transfer with nothing predicted: out_byte %02h key_byte %02h",
                      rsp_data.out_byte, rsp_data.key_byte);
               mismatch_count++;
            end else begin
               want_rsp = keystream_out_q.pop_front();
               if (rsp_data.out_byte !== want_rsp.out_byte) begin
                  $error("out_byte: expected %02h, got %02h",
                         want_rsp.out_byte, rsp_data.out_byte);
                  mismatch_count++;
               end
               if (rsp_data.key_byte !== want_rsp.key_byte) begin
                  $error("key_byte: expected %02h, got %02h",
                         want_rsp.key_byte, rsp_data.key_byte);
                  mismatch_count++;
               end
               if (rsp_data.valid_res !== want_rsp.valid_res) begin
                  $error("valid_res: expected %0b, got %0b",
                         want_rsp.valid_res, rsp_data.valid_res);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence: fill the item queue, release reset, wait for the drain
   // ------------------------------------------------------------------------
   initial begin
      int pick;
      int n;
      int rand_count;
      int total_items;

      // generate before any load: answers zero, state untouched
      queue_item(FUNC_GEN, 8'hFF, 8'hFF);
      queue_item(FUNC_GEN, 8'h00, 8'h00);

      // partial load: S[1] = 1 makes j = 1, so the step reads only S[1]
      // and S[2]; key comes out as S[2]
      queue_item(FUNC_LOAD, 8'h01, 8'h01);
      queue_item(FUNC_LOAD, 8'h02, 8'hA5);
      queue_item(FUNC_GEN, 8'h7E, 8'h3C);

      // full permutation, then a stream of generates with edge data
      queue_full_load();
      queue_item(FUNC_GEN, 8'h00, 8'h00);
      queue_item(FUNC_GEN, 8'hFF, 8'hFF);
      queue_item(FUNC_GEN, 8'h55, 8'h55);
      queue_item(FUNC_GEN, 8'hAA, 8'hAA);
      queue_item(FUNC_GEN, 8'h0F, 8'hF0);
      queue_item(FUNC_GEN, 8'hF0, 8'h0F);

      // load extremes of index and value, each restarting the pointers
      queue_item(FUNC_LOAD, 8'hFF, 8'h00);
      queue_item(FUNC_GEN, 8'h12, 8'h80);
      queue_item(FUNC_LOAD, 8'h00, 8'hFF);
      queue_item(FUNC_GEN, 8'h34, 8'h01);
      queue_item(FUNC_GEN, 8'h56, 8'hFE);
      queue_item(FUNC_GEN, 8'h78, 8'h7F);

      // random part: every entry is written by now, so any mix is legal;
      // mostly generate bursts, some stray loads, now and then a new key
      rand_count = 0;
      while (rand_count < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 39);
         if (pick == 0) begin
            queue_full_load();
            rand_count += 256;
         end else if (pick <= 6) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               queue_item(FUNC_LOAD, octet_type'($urandom()), octet_type'($urandom()));
            end
            rand_count += n;
         end else begin
            n = $urandom_range(4, 40);
            repeat (n) begin
               queue_item(FUNC_GEN, octet_type'($urandom()), octet_type'($urandom()));
            end
            rand_count += n;
         end
      end
      total_items = pending_req_q.size();

      // hold reset, then drop it on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (accepted_count == total_items);
      wait (keystream_out_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
